FILE: src/bbox_kalman_tracker_filter_top_assert.svh
// Assertion macros for the bounding-box tracking filter.
`ifndef BBOX_KALMAN_TRACKER_FILTER_TOP_ASSERT_SVH
`define BBOX_KALMAN_TRACKER_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BKF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bkf_pkg.sv
// Types, constants and saturation helpers shared by the tracking filter modules.
`default_nettype none
package bkf_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS   = 16;
  localparam int RECIP_FRAC  = 32;
  localparam int WEIGHT_FRAC = 16;
  localparam int ST_W        = 32;
  localparam int COV_W       = 48;
  localparam int GAIN_W      = 63;
  localparam int WT_W        = 16;
  localparam int Y_W         = ST_W + 1;
  localparam int INV_W       = FRAC_BITS + RECIP_FRAC;
  localparam int DIV_W       = INV_W + 1;
  localparam int ACC_W       = COV_W + 4;
  localparam int MUL_W       = 64;

  // Request codes.
  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_PREDICT = 2'd1;
  localparam logic [1:0] REQ_UPDATE  = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic CFG_STD_POS = 1'b0;
  localparam logic CFG_STD_VEL = 1'b1;
  localparam logic [WT_W-1:0] STD_POS_RST = 16'd3277;
  localparam logic [WT_W-1:0] STD_VEL_RST = 16'd410;

  // Post-multiply shift selection.
  localparam logic [1:0] MSH_WEIGHT = 2'd0;
  localparam logic [1:0] MSH_FRAC   = 2'd1;
  localparam logic [1:0] MSH_RECIP  = 2'd2;

  // One request to the shared multiplier.
  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    logic [1:0]              sh;
    logic                    sat48;
  } mul_req_t;

  // Saturate an accumulator to a covariance term.
  function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:COV_W-1]) || !(|v[ACC_W-1:COV_W-1])) begin
      return v[COV_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(COV_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COV_W-1){1'b1}}};
    end
  endfunction

  // Saturate an accumulator to a state term.
  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:ST_W-1]) || !(|v[ACC_W-1:ST_W-1])) begin
      return v[ST_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ST_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/bbox_kalman_tracker_filter_top.sv
// Top level of the bounding-box tracking Kalman filter with covariance memory.
// Channel | Direction | Handshake            | Payload
// cfg     | in        | cfg_we               | cfg_idx, cfg_wdata
// in      | in        | in_valid / in_ready  | in_req_type, in_meas_*
// out     | out       | out_valid / out_ready| out_est_*
// One transaction at a time. The run time of each request is set by the shared sequential
// multiplier and the single read port of the covariance memory. Reset clears the state and
// the covariance valid bits and loads the weights with their reset values at once; no
// clearing pass. A new transaction is taken while a result waits on the output; the
// sequencer holds its final step until the output is free.
`default_nettype none
module bbox_kalman_tracker_filter_top import bkf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_idx,
  input  logic [WT_W-1:0]        cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_req_type,
  input  logic signed [ST_W-1:0] in_meas_pos_x,
  input  logic signed [ST_W-1:0] in_meas_pos_y,
  input  logic signed [ST_W-1:0] in_meas_size_a,
  input  logic signed [ST_W-1:0] in_meas_size_b,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [ST_W-1:0] out_est_pos_x,
  output logic signed [ST_W-1:0] out_est_pos_y,
  output logic signed [ST_W-1:0] out_est_size_a,
  output logic signed [ST_W-1:0] out_est_size_b,
  output logic signed [ST_W-1:0] out_est_vel_x,
  output logic signed [ST_W-1:0] out_est_vel_y,
  output logic signed [ST_W-1:0] out_est_vel_a,
  output logic signed [ST_W-1:0] out_est_vel_b
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAL   = 4'd1;
  localparam logic [3:0] ST_INITW  = 4'd2;
  localparam logic [3:0] ST_PX     = 4'd3;
  localparam logic [3:0] ST_PADD   = 4'd4;
  localparam logic [3:0] ST_UY     = 4'd5;
  localparam logic [3:0] ST_UINV   = 4'd6;
  localparam logic [3:0] ST_UGAIN  = 4'd7;
  localparam logic [3:0] ST_USTATE = 4'd8;
  localparam logic [3:0] ST_UCOV   = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // Sequencer control.
  logic [3:0]  state_r;
  logic [2:0]  sub_r;
  logic [1:0]  sc_r;
  logic [5:0]  e_r;
  logic [1:0]  k_r;
  logic [1:0]  pass_r;
  logic        bank_r;
  logic        out_valid_r;

  // Working data.
  logic [1:0]              req_r;
  logic [WT_W-1:0]         wp_r, wv_r;
  logic signed [ST_W-1:0]  z_r [4];
  logic signed [ST_W-1:0]  x_r [8];
  logic signed [ST_W-1:0]  out_r [8];
  logic signed [MUL_W-1:0] sp_r, sv_r, qa_r, qb_r;
  logic signed [Y_W-1:0]   y_r [4];
  logic [INV_W-1:0]        inv_r [4];
  logic signed [COV_W-1:0] opa_r;
  logic signed [COV_W-1:0] d_r;
  logic signed [ACC_W-1:0] acc_r;

  // Covariance memory: two banks of 64 terms, with a valid bit per entry.
  logic signed [COV_W-1:0] cov_mem [128];
  logic                    cov_vld_r [128];
  logic signed [COV_W-1:0] cov_rd_r;
  logic                    cov_rd_vld_r;
  logic [6:0]              cov_raddr, cov_waddr;
  logic                    cov_we;
  logic signed [COV_W-1:0] cov_wdata;
  logic signed [COV_W-1:0] cov_q;

  // Gain memory: 8 x 4 gains.
  logic signed [GAIN_W-1:0] gain_mem [32];
  logic signed [GAIN_W-1:0] gain_rd_r;
  logic [4:0]               gain_raddr;
  logic                     gain_we;

  // Multiplier interface.
  mul_req_t                mul_req;
  logic                    mul_start;
  logic                    mul_done;
  logic signed [MUL_W-1:0] mul_res;

  // Reciprocal divider.
  logic [DIV_W-1:0]  div_q_r;
  logic [COV_W-1:0]  div_rem_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              div_busy_r;
  logic              div_done_r;
  logic              div_start;
  logic [COV_W:0]    div_t;
  logic              div_ge;

  // Derived values.
  logic [5:0]              a_idx, b_idx;
  logic signed [COV_W-1:0] q_sel;
  logic signed [COV_W-1:0] d_c;
  logic signed [ACC_W-1:0] acc_st, acc_cv, padd_sum;

  assign cov_q = cov_rd_vld_r ? cov_rd_r : '0;

  // Element addresses of the predict passes: rows, columns, then the diagonal.
  always_comb begin
    case (pass_r)
      2'd0: begin
        a_idx = {1'b0, e_r[4:3], e_r[2:0]};
        b_idx = {1'b1, e_r[4:3], e_r[2:0]};
      end
      2'd1: begin
        a_idx = {e_r[2:0], 1'b0, e_r[4:3]};
        b_idx = {e_r[2:0], 1'b1, e_r[4:3]};
      end
      default: begin
        a_idx = {e_r[2:0], e_r[2:0]};
        b_idx = {e_r[2:0], e_r[2:0]};
      end
    endcase
  end

  // Arithmetic on the data just read.
  always_comb begin
    q_sel    = e_r[2] ? qb_r[COV_W-1:0] : qa_r[COV_W-1:0];
    padd_sum = ACC_W'(opa_r) + ((pass_r == 2'd2) ? ACC_W'(q_sel) : ACC_W'(cov_q));
    d_c      = sat_cov(ACC_W'(cov_q) + ACC_W'($signed(qa_r[COV_W-1:0])));
    acc_st   = ((k_r == 2'd0) ? ACC_W'(x_r[e_r[2:0]]) : acc_r)
               + $signed(mul_res[ACC_W-1:0]);
    acc_cv   = acc_r - $signed(mul_res[ACC_W-1:0]);
  end

  // Memory, multiplier and divider controls from the sequencer step.
  always_comb begin
    cov_raddr  = '0;
    cov_we     = 1'b0;
    cov_waddr  = '0;
    cov_wdata  = '0;
    gain_raddr = '0;
    gain_we    = 1'b0;
    mul_start  = 1'b0;
    mul_req    = '{a: '0, b: '0, sh: MSH_FRAC, sat48: 1'b0};
    div_start  = 1'b0;
    case (state_r)
      ST_SCAL: begin
        mul_start = (sub_r == 3'd0);
        case (sc_r)
          2'd0: begin
            mul_req.a = (req_r == REQ_INIT) ? (MUL_W'(wp_r) << 1) : MUL_W'(wp_r);
            mul_req.b = (req_r == REQ_INIT) ? MUL_W'(z_r[2]) : MUL_W'(x_r[2]);
            mul_req.sh = MSH_WEIGHT;
          end
          2'd1: begin
            mul_req.a = (req_r == REQ_INIT) ? (MUL_W'(wv_r) * MUL_W'(10)) : MUL_W'(wv_r);
            mul_req.b = (req_r == REQ_INIT) ? MUL_W'(z_r[2]) : MUL_W'(x_r[2]);
            mul_req.sh = MSH_WEIGHT;
          end
          2'd2: begin
            mul_req.a     = sp_r;
            mul_req.b     = (req_r == REQ_INIT) ? (sp_r <<< 2) : sp_r;
            mul_req.sat48 = 1'b1;
          end
          default: begin
            mul_req.a     = sv_r;
            mul_req.b     = (req_r == REQ_INIT) ? (sv_r <<< 2) : sv_r;
            mul_req.sat48 = 1'b1;
          end
        endcase
      end
      ST_INITW: begin
        cov_we    = 1'b1;
        cov_waddr = {bank_r, e_r};
        if (e_r[5:3] == e_r[2:0]) begin
          cov_wdata = e_r[5] ? qb_r[COV_W-1:0] : qa_r[COV_W-1:0];
        end
      end
      ST_PADD: begin
        cov_raddr = {bank_r, (sub_r == 3'd0) ? a_idx : b_idx};
        if (sub_r == 3'd2) begin
          cov_we    = 1'b1;
          cov_waddr = {bank_r, a_idx};
          cov_wdata = sat_cov(padd_sum);
        end
      end
      ST_UINV: begin
        cov_raddr = {bank_r, 1'b0, k_r, 1'b0, k_r};
        div_start = (sub_r == 3'd1) && (d_c > 48'sd1);
      end
      ST_UGAIN: begin
        cov_raddr     = {bank_r, e_r[4:2], 1'b0, e_r[1:0]};
        mul_start     = (sub_r == 3'd1);
        mul_req.a     = MUL_W'(cov_q);
        mul_req.b     = $signed(MUL_W'(inv_r[e_r[1:0]]));
        gain_we       = (sub_r == 3'd2) && mul_done;
      end
      ST_USTATE: begin
        gain_raddr    = {e_r[2:0], k_r};
        mul_start     = (sub_r == 3'd1);
        mul_req.a     = MUL_W'(gain_rd_r);
        mul_req.b     = MUL_W'(y_r[k_r]);
        mul_req.sh    = MSH_RECIP;
        mul_req.sat48 = 1'b1;
      end
      ST_UCOV: begin
        cov_raddr     = (sub_r == 3'd0) ? {bank_r, e_r} : {bank_r, 1'b0, k_r, e_r[2:0]};
        gain_raddr    = {e_r[5:3], k_r};
        mul_start     = (sub_r == 3'd3);
        mul_req.a     = MUL_W'(gain_rd_r);
        mul_req.b     = MUL_W'(cov_q);
        mul_req.sh    = MSH_RECIP;
        mul_req.sat48 = 1'b1;
        if ((sub_r == 3'd4) && mul_done && (k_r == 2'd3)) begin
          cov_we    = 1'b1;
          cov_waddr = {~bank_r, e_r};
          cov_wdata = sat_cov(acc_cv);
        end
      end
      default: begin
        cov_raddr = '0;
      end
    endcase
  end

  // Covariance memory array and its registered read.
  always_ff @(posedge clk) begin
    if (cov_we) begin
      cov_mem[cov_waddr] <= cov_wdata;
    end
    cov_rd_r <= cov_mem[cov_raddr];
  end

  // Covariance valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 128; n++) begin
        cov_vld_r[n] <= 1'b0;
      end
      cov_rd_vld_r <= 1'b0;
    end else begin
      if (cov_we) begin
        cov_vld_r[cov_waddr] <= 1'b1;
      end
      cov_rd_vld_r <= cov_vld_r[cov_raddr];
    end
  end

  // Gain memory array and its registered read.
  always_ff @(posedge clk) begin
    if (gain_we) begin
      gain_mem[e_r[4:0]] <= mul_res[GAIN_W-1:0];
    end
    gain_rd_r <= gain_mem[gain_raddr];
  end

  // Restoring divider, one quotient bit a cycle.
  always_comb begin
    div_t  = {div_rem_r, div_q_r[DIV_W-1]};
    div_ge = (div_t >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (div_start) begin
        div_q_r    <= (DIV_W'(1) << INV_W) + DIV_W'(d_c[COV_W-1:1]);
        div_rem_r  <= '0;
        div_cnt_r  <= DCNT_W'(DIV_W);
        div_busy_r <= 1'b1;
      end else if (div_busy_r) begin
        div_rem_r <= div_ge ? COV_W'(div_t - {1'b0, d_r}) : div_t[COV_W-1:0];
        div_q_r   <= {div_q_r[DIV_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r - DCNT_W'(1);
        if (div_cnt_r == DCNT_W'(1)) begin
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
        end
      end
    end
  end

  // Shared multiplier.
  bkf_mulsh u_mulsh (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sub_r       <= '0;
      sc_r        <= '0;
      e_r         <= '0;
      k_r         <= '0;
      pass_r      <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wp_r        <= STD_POS_RST;
      wv_r        <= STD_VEL_RST;
      for (int n = 0; n < 8; n++) begin
        x_r[n] <= '0;
      end
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        case (cfg_idx)
          CFG_STD_POS: wp_r <= cfg_wdata;
          CFG_STD_VEL: wv_r <= cfg_wdata;
          default:     wp_r <= wp_r;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            req_r  <= in_req_type;
            z_r[0] <= in_meas_pos_x;
            z_r[1] <= in_meas_pos_y;
            z_r[2] <= in_meas_size_a;
            z_r[3] <= in_meas_size_b;
            sc_r   <= '0;
            sub_r  <= '0;
            if (in_req_type inside {REQ_INIT, REQ_PREDICT, REQ_UPDATE}) begin
              state_r <= ST_SCAL;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        // Noise scalars, one product at a time.
        ST_SCAL: begin
          if (sub_r == 3'd0) begin
            sub_r <= 3'd1;
          end else if (mul_done) begin
            case (sc_r)
              2'd0:    sp_r <= mul_res;
              2'd1:    sv_r <= mul_res;
              2'd2:    qa_r <= mul_res;
              default: qb_r <= mul_res;
            endcase
            sub_r <= 3'd0;
            sc_r  <= sc_r + 2'd1;
            e_r   <= '0;
            k_r   <= '0;
            if (sc_r == 2'd3) begin
              case (req_r)
                REQ_INIT: begin
                  for (int n = 0; n < 4; n++) begin
                    x_r[n]     <= z_r[n];
                    x_r[n + 4] <= '0;
                  end
                  state_r <= ST_INITW;
                end
                REQ_PREDICT: state_r <= ST_PX;
                default:     state_r <= ST_UY;
              endcase
            end
          end
        end
        // Init writes the diagonal covariance over the whole bank.
        ST_INITW: begin
          e_r <= e_r + 6'd1;
          if (&e_r) begin
            state_r <= ST_DONE;
          end
        end
        // Constant-velocity step on the state.
        ST_PX: begin
          for (int n = 0; n < 4; n++) begin
            x_r[n] <= sat_st(ACC_W'(x_r[n]) + ACC_W'(x_r[n + 4]));
          end
          pass_r  <= '0;
          e_r     <= '0;
          sub_r   <= '0;
          state_r <= ST_PADD;
        end
        // Read, read, write back; the next read follows the write.
        ST_PADD: begin
          case (sub_r)
            3'd0: sub_r <= 3'd1;
            3'd1: begin
              opa_r <= cov_q;
              sub_r <= 3'd2;
            end
            default: begin
              sub_r <= 3'd0;
              if ((pass_r == 2'd2) ? (e_r[2:0] == 3'd7) : (e_r[4:0] == 5'd31)) begin
                e_r <= '0;
                if (pass_r == 2'd2) begin
                  state_r <= ST_DONE;
                end else begin
                  pass_r <= pass_r + 2'd1;
                end
              end else begin
                e_r <= e_r + 6'd1;
              end
            end
          endcase
        end
        // Innovation, taken before the state changes.
        ST_UY: begin
          for (int n = 0; n < 4; n++) begin
            y_r[n] <= Y_W'(z_r[n]) - Y_W'(x_r[n]);
          end
          k_r     <= '0;
          sub_r   <= '0;
          state_r <= ST_UINV;
        end
        // Reciprocals of the innovation diagonal.
        ST_UINV: begin
          case (sub_r)
            3'd0: sub_r <= 3'd1;
            3'd1: begin
              d_r <= d_c;
              if (d_c > 48'sd1) begin
                sub_r <= 3'd2;
              end else begin
                inv_r[k_r] <= '0;
                sub_r      <= 3'd0;
                k_r        <= k_r + 2'd1;
                e_r        <= '0;
                if (k_r == 2'd3) begin
                  state_r <= ST_UGAIN;
                end
              end
            end
            default: begin
              if (div_done_r) begin
                inv_r[k_r] <= div_q_r[INV_W-1:0];
                sub_r      <= 3'd0;
                k_r        <= k_r + 2'd1;
                e_r        <= '0;
                if (k_r == 2'd3) begin
                  state_r <= ST_UGAIN;
                end
              end
            end
          endcase
        end
        // Gains from the first four covariance columns.
        ST_UGAIN: begin
          case (sub_r)
            3'd0: sub_r <= 3'd1;
            3'd1: sub_r <= 3'd2;
            default: begin
              if (mul_done) begin
                sub_r <= 3'd0;
                k_r   <= '0;
                if (e_r[4:0] == 5'd31) begin
                  e_r     <= '0;
                  state_r <= ST_USTATE;
                end else begin
                  e_r <= e_r + 6'd1;
                end
              end
            end
          endcase
        end
        // State correction, four products a term.
        ST_USTATE: begin
          case (sub_r)
            3'd0: sub_r <= 3'd1;
            3'd1: sub_r <= 3'd2;
            default: begin
              if (mul_done) begin
                acc_r <= acc_st;
                sub_r <= 3'd0;
                k_r   <= k_r + 2'd1;
                if (k_r == 2'd3) begin
                  x_r[e_r[2:0]] <= sat_st(acc_st);
                  if (e_r[2:0] == 3'd7) begin
                    e_r     <= '0;
                    state_r <= ST_UCOV;
                  end else begin
                    e_r <= e_r + 6'd1;
                  end
                end
              end
            end
          endcase
        end
        // Covariance correction into the other bank, old terms read throughout.
        ST_UCOV: begin
          case (sub_r)
            3'd0: sub_r <= 3'd1;
            3'd1: begin
              acc_r <= ACC_W'(cov_q);
              k_r   <= '0;
              sub_r <= 3'd2;
            end
            3'd2: sub_r <= 3'd3;
            3'd3: sub_r <= 3'd4;
            default: begin
              if (mul_done) begin
                acc_r <= acc_cv;
                if (k_r == 2'd3) begin
                  sub_r <= 3'd0;
                  e_r   <= e_r + 6'd1;
                  if (&e_r) begin
                    bank_r  <= ~bank_r;
                    state_r <= ST_DONE;
                  end
                end else begin
                  k_r   <= k_r + 2'd1;
                  sub_r <= 3'd2;
                end
              end
            end
          endcase
        end
        // Hand the state to the output register once it is free.
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            for (int n = 0; n < 8; n++) begin
              out_r[n] <= x_r[n];
            end
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_est_pos_x  = out_r[0];
  assign out_est_pos_y  = out_r[1];
  assign out_est_size_a = out_r[2];
  assign out_est_size_b = out_r[3];
  assign out_est_vel_x  = out_r[4];
  assign out_est_vel_y  = out_r[5];
  assign out_est_vel_a  = out_r[6];
  assign out_est_vel_b  = out_r[7];

  // Checks on the sequencer and its shared units.
`include "bbox_kalman_tracker_filter_top_assert.svh"
  `BKF_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != ST_IDLE, "transaction accepted but sequencer stayed idle")
  `BKF_ASSERT_SAME(a_div_done_expected, clk, rst_n, div_done_r, (state_r == ST_UINV) && (sub_r == 3'd2), "reciprocal finished outside its wait step")
  `BKF_ASSERT_SAME(a_mul_done_expected, clk, rst_n, mul_done, ((state_r == ST_SCAL) && (sub_r == 3'd1)) || (((state_r == ST_UGAIN) || (state_r == ST_USTATE)) && (sub_r == 3'd2)) || ((state_r == ST_UCOV) && (sub_r == 3'd4)), "product finished outside a wait step")

endmodule
`default_nettype wire

FILE: src/bkf_mulsh.sv
// Shared sequential multiplier: 32x32 partial products, rounding shift and saturation.
`default_nettype none
module bkf_mulsh import bkf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  mul_req_t                req,
  output logic                    done,
  output logic signed [MUL_W-1:0] res
);

  localparam logic [1:0] MP_IDLE = 2'd0;
  localparam logic [1:0] MP_MUL  = 2'd1;
  localparam logic [1:0] MP_RND  = 2'd2;
  localparam logic [1:0] MP_SAT  = 2'd3;

  logic [1:0]              ph_r;
  logic [2:0]              cnt_r;
  logic [1:0]              pc_r;
  logic [MUL_W-1:0]        ua_r, ub_r;
  logic                    neg_r;
  logic [1:0]              sh_r;
  logic                    sat48_r;
  logic [MUL_W-1:0]        pp_r;
  logic [2*MUL_W-1:0]      acc_r, sr_r;
  logic                    done_r;
  logic signed [MUL_W-1:0] res_r;

  logic [MUL_W-1:0]        ua_c, ub_c;
  logic [31:0]             pa, pb;
  logic [2*MUL_W-1:0]      pp_ext, sr_c;
  logic [MUL_W-1:0]        lim, mag;

  // Magnitudes of the operands and the halves for the current partial product.
  always_comb begin
    ua_c = req.a[MUL_W-1] ? (MUL_W'(0) - req.a) : req.a;
    ub_c = req.b[MUL_W-1] ? (MUL_W'(0) - req.b) : req.b;
    pa   = cnt_r[0] ? ua_r[MUL_W-1:32] : ua_r[31:0];
    pb   = cnt_r[1] ? ub_r[MUL_W-1:32] : ub_r[31:0];
  end

  // Place the previous partial product at its weight.
  always_comb begin
    case (pc_r)
      2'd0:    pp_ext = {64'd0, pp_r};
      2'd3:    pp_ext = {pp_r, 64'd0};
      default: pp_ext = {32'd0, pp_r, 32'd0};
    endcase
  end

  // Round half away from zero on the magnitude, then shift.
  always_comb begin
    case (sh_r)
      MSH_WEIGHT: sr_c = (acc_r + (128'd1 << (WEIGHT_FRAC-1))) >> WEIGHT_FRAC;
      MSH_RECIP:  sr_c = (acc_r + (128'd1 << (RECIP_FRAC-1))) >> RECIP_FRAC;
      default:    sr_c = (acc_r + (128'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
    endcase
  end

  // Saturation limit depends on the sign of the result.
  always_comb begin
    lim = sat48_r ? (64'd1 << (COV_W-1)) : (64'd1 << (GAIN_W-1));
    if (!neg_r) begin
      lim = lim - 64'd1;
    end
    mag = ((|sr_r[2*MUL_W-1:MUL_W]) || (sr_r[MUL_W-1:0] > lim)) ? lim : sr_r[MUL_W-1:0];
  end

  // Sequencer: four partial products, round, saturate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MP_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        MP_IDLE: begin
          if (start) begin
            ua_r    <= ua_c;
            ub_r    <= ub_c;
            neg_r   <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
            sh_r    <= req.sh;
            sat48_r <= req.sat48;
            acc_r   <= '0;
            cnt_r   <= 3'd0;
            ph_r    <= MP_MUL;
          end
        end
        MP_MUL: begin
          if (cnt_r != 3'd4) begin
            pp_r <= pa * pb;
            pc_r <= cnt_r[1:0];
          end
          if (cnt_r != 3'd0) begin
            acc_r <= acc_r + pp_ext;
          end
          if (cnt_r == 3'd4) begin
            ph_r <= MP_RND;
          end
          cnt_r <= cnt_r + 3'd1;
        end
        MP_RND: begin
          sr_r <= sr_c;
          ph_r <= MP_SAT;
        end
        MP_SAT: begin
          res_r  <= neg_r ? $signed(MUL_W'(0) - mag) : $signed(mag);
          done_r <= 1'b1;
          ph_r   <= MP_IDLE;
        end
        default: ph_r <= MP_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire
